FILE: rtl/core/krt_pkg.sv
package krt_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned ROLE_W   = 8;
  localparam int unsigned SAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ROLE_W-1:0] role;
    logic [SAL_W-1:0]  salary;
  } record_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    idx;
    record_t             rec;
    logic                last;
  } rsp_t;

endpackage

FILE: rtl/core/krt_req_if.sv
interface krt_req_if;
  import krt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  search_key;
  logic [KEY_W-1:0]  new_key;
  logic [ROLE_W-1:0] role_in;
  logic [SAL_W-1:0]  salary_in;

  modport source (
    output valid, cmd, search_key, new_key, role_in, salary_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, search_key, new_key, role_in, salary_in,
    output ready
  );
endinterface

FILE: rtl/core/krt_rsp_if.sv
interface krt_rsp_if;
  import krt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    entry_index;
  logic [KEY_W-1:0]    key_out;
  logic [ROLE_W-1:0]   role_out;
  logic [SAL_W-1:0]    salary_out;
  logic                last;

  modport source (
    output valid, status, entry_index, key_out, role_out, salary_out, last,
    input  ready
  );

  modport sink (
    input  valid, status, entry_index, key_out, role_out, salary_out, last,
    output ready
  );
endinterface

FILE: rtl/core/krt_ram.sv
// Record store: one write port, one read port, registered read data.
module krt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  krt_pkg::record_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output krt_pkg::record_t rdata_o
);
  import krt_pkg::*;

  record_t mem_q [DEPTH];
  record_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/keyed_record_table.sv
// Keyed record table. Holds up to TABLE_DEPTH records (31-bit key, 8-bit role,
// 32-bit salary in cents) in insertion order, in a single-port-read RAM. One
// request is taken at a time; req_i.ready is low while a request is being
// worked and while a response waits to be taken. Insert answers in the cycle
// after acceptance (status full once the table holds TABLE_DEPTH records).
// Lookup, update and delete walk the RAM from position 0, one record per
// cycle, and act on the first key match. Delete then moves each later record
// down, one per cycle. Dump returns one response per record, in order, with
// last on the final one, and loads the next record only once the previous
// response has been taken. No clearing pass is needed after reset: only the
// records at positions below the record count are ever used.
module keyed_record_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  krt_req_if.sink       req_i,
  krt_rsp_if.source     rsp_o
);
  import krt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);     // RAM address width
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1); // record count width

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1; // compare keys, one record a cycle
  localparam logic [2:0] S_SHIFT     = 3'd2; // close the gap after a delete
  localparam logic [2:0] S_DUMP      = 3'd3; // load next record into the response
  localparam logic [2:0] S_DUMP_WAIT = 3'd4; // wait for that response to go

  logic [2:0]        state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d;

  // latched request
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [KEY_W-1:0]  skey_q, skey_d;
  logic [KEY_W-1:0]  nkey_q, nkey_d;
  logic [ROLE_W-1:0] role_q, role_d;
  logic [SAL_W-1:0]  sal_q, sal_d;

  // response register
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  // RAM port
  logic              we;
  logic [IW-1:0]     waddr;
  logic [IW-1:0]     raddr;
  record_t           wdata;
  record_t           rdata;

  logic              req_fire;
  logic              key_hit;
  logic              last_idx;
  logic [IW-1:0]     idx_inc;
  record_t           upd_rec;

  krt_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_krt_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign req_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign req_fire    = req_i.valid && req_i.ready;

  // the one comparator shared by every scan step
  assign key_hit  = (rdata.key == skey_q);
  assign last_idx = ((CW'(idx_q) + CW'(1)) == count_q);
  assign idx_inc  = idx_q + IW'(1);

  assign upd_rec.key    = nkey_q;
  assign upd_rec.role   = role_q;
  assign upd_rec.salary = sal_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    skey_d      = skey_q;
    nkey_d      = nkey_q;
    role_d      = role_q;
    sal_d       = sal_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata;
    raddr       = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          cmd_d  = req_i.cmd;
          skey_d = req_i.search_key;
          nkey_d = req_i.new_key;
          role_d = req_i.role_in;
          sal_d  = req_i.salary_in;
          case (req_i.cmd) inside
            CMD_INSERT: begin
              out_valid_d = 1'b1;
              out_d.last  = 1'b1;
              if (count_q == CW'(TABLE_DEPTH)) begin
                out_d.status = ST_FULL;
                out_d.idx    = '0;
                out_d.rec    = '0;
              end else begin
                we           = 1'b1;
                waddr        = count_q[IW-1:0];
                wdata.key    = req_i.search_key;
                wdata.role   = req_i.role_in;
                wdata.salary = req_i.salary_in;
                out_d.status = ST_OK;
                out_d.idx    = IDX_W'(count_q[IW-1:0]);
                out_d.rec    = wdata;
                count_d      = count_q + CW'(1);
              end
            end
            CMD_LOOKUP, CMD_UPDATE, CMD_DELETE: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = ST_NOTFOUND;
                out_d.idx    = '0;
                out_d.rec    = '0;
                out_d.last   = 1'b1;
              end else begin
                idx_d   = '0;
                raddr   = '0;
                state_d = S_SCAN;
              end
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = ST_EMPTY;
                out_d.idx    = '0;
                out_d.rec    = '0;
                out_d.last   = 1'b1;
              end else begin
                idx_d   = '0;
                raddr   = '0;
                state_d = S_DUMP;
              end
            end
            default: begin
              // unused codes: dropped without a response
            end
          endcase
        end
      end

      S_SCAN: begin
        if (key_hit) begin
          out_valid_d  = 1'b1;
          out_d.status = ST_OK;
          out_d.idx    = IDX_W'(idx_q);
          out_d.rec    = rdata;
          out_d.last   = 1'b1;
          state_d      = S_IDLE;
          case (cmd_q)
            CMD_UPDATE: begin
              we        = 1'b1;
              wdata     = upd_rec;
              out_d.rec = upd_rec;
            end
            CMD_DELETE: begin
              if (last_idx) begin
                count_d = count_q - CW'(1);
              end else begin
                idx_d   = idx_inc;
                raddr   = idx_inc;
                state_d = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end else if (last_idx) begin
          out_valid_d  = 1'b1;
          out_d.status = ST_NOTFOUND;
          out_d.idx    = '0;
          out_d.rec    = '0;
          out_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_inc;
          raddr = idx_inc;
        end
      end

      S_SHIFT: begin
        // rdata holds record idx_q; move it down one place
        we    = 1'b1;
        waddr = idx_q - IW'(1);
        if (last_idx) begin
          count_d = count_q - CW'(1);
          state_d = S_IDLE;
        end else begin
          idx_d = idx_inc;
          raddr = idx_inc;
        end
      end

      S_DUMP: begin
        out_valid_d  = 1'b1;
        out_d.status = ST_OK;
        out_d.idx    = IDX_W'(idx_q);
        out_d.rec    = rdata;
        out_d.last   = last_idx;
        if (last_idx) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_inc;
          raddr   = idx_inc;
          state_d = S_DUMP_WAIT;
        end
      end

      S_DUMP_WAIT: begin
        // raddr holds idx_q, so rdata is ready for the next load
        if (out_valid_q && rsp_o.ready) begin
          state_d = S_DUMP;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    skey_q <= skey_d;
    nkey_q <= nkey_d;
    role_q <= role_d;
    sal_q  <= sal_d;
    out_q  <= out_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.entry_index = out_q.idx;
  assign rsp_o.key_out     = out_q.rec.key;
  assign rsp_o.role_out    = out_q.rec.role;
  assign rsp_o.salary_out  = out_q.rec.salary;
  assign rsp_o.last        = out_q.last;

endmodule

FILE: rtl/core/krt_checker.sv
module krt_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  logic                    req_ready_i,
  input  logic [krt_pkg::CMD_W-1:0]    req_cmd_i,
  input  logic                    rsp_valid_i,
  input  logic                    rsp_ready_i,
  input  logic [krt_pkg::STATUS_W-1:0] rsp_status_i,
  input  logic [krt_pkg::IDX_W-1:0]    rsp_entry_index_i,
  input  logic [krt_pkg::KEY_W-1:0]    rsp_key_i,
  input  logic [krt_pkg::ROLE_W-1:0]   rsp_role_i,
  input  logic [krt_pkg::SAL_W-1:0]    rsp_salary_i,
  input  logic                    rsp_last_i
);
  import krt_pkg::*;

  // no new request while a response is still pending
  a_no_req_while_rsp: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i
  ) else $error("request port ready while response pending");

  // a valid command keeps the request side closed the next cycle
  a_busy_after_cmd: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && (req_cmd_i <= CMD_DUMP)) |=> !req_ready_i
  ) else $error("request port ready straight after a command");

  // error responses are final and carry no record
  a_error_rsp_clean: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i != ST_OK)) |->
      (rsp_last_i && (rsp_entry_index_i == '0) && (rsp_key_i == '0) &&
       (rsp_role_i == '0) && (rsp_salary_i == '0))
  ) else $error("error response with record data or without last");

  // stalled response holds
  a_rsp_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_entry_index_i) &&
       $stable(rsp_key_i) && $stable(rsp_role_i) && $stable(rsp_salary_i) &&
       $stable(rsp_last_i))
  ) else $error("stalled response changed");

endmodule

bind keyed_record_table krt_checker u_krt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .req_cmd_i         (req_i.cmd),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_entry_index_i (rsp_o.entry_index),
  .rsp_key_i         (rsp_o.key_out),
  .rsp_role_i        (rsp_o.role_out),
  .rsp_salary_i      (rsp_o.salary_out),
  .rsp_last_i        (rsp_o.last)
);
